FILE: hw/rtl/srec_pkg.sv
// ----------------------------------------------------------------------------
// srec_pkg
// Shared constants, types and the hex decode function for the S-record line
// checker.
// ----------------------------------------------------------------------------
package srec_pkg;

    // ASCII codes
    localparam logic [7:0] CHAR_S       = 8'd83;
    localparam logic [7:0] CHAR_0       = 8'd48;
    localparam logic [7:0] CHAR_9       = 8'd57;
    localparam logic [7:0] CHAR_A       = 8'd65;
    localparam logic [7:0] CHAR_F       = 8'd70;
    localparam logic [7:0] HEX_A_OFFSET = 8'd55;

    // decode of a character that is not a hex digit
    localparam logic [4:0] NIBBLE_BAD   = 5'd16;

    // record type codes
    localparam logic [3:0] REC_S0       = 4'd0;
    localparam logic [3:0] REC_S4       = 4'd4;
    localparam logic [3:0] REC_S6       = 4'd6;
    localparam logic [3:0] REC_NONE     = 4'd10;
    localparam int         REC_TYPES    = 10;

    localparam logic [9:0] POS_MAX      = 10'd1023;

    // per-line status after the current character has been taken
    typedef struct packed {
        logic       start_is_s;
        logic [7:0] type_char;
        logic       checksum_done;
        logic       checksum_match;
    } line_status_t;

    function automatic logic [4:0] decode_nibble(input logic [7:0] c);
        logic [7:0] diff;
        begin
            diff = 8'd0;
            if (c >= CHAR_0 && c <= CHAR_9)
            begin
                diff = c - CHAR_0;
                decode_nibble = diff[4:0];
            end
            else if (c >= CHAR_A && c <= CHAR_F)
            begin
                diff = c - HEX_A_OFFSET;
                decode_nibble = diff[4:0];
            end
            else
            begin
                decode_nibble = NIBBLE_BAD;
            end
        end
    endfunction

endpackage

FILE: hw/rtl/srec_char_if.sv
// ----------------------------------------------------------------------------
// srec_char_if
// Character stream channel: one text character per beat, with a line end flag.
// ----------------------------------------------------------------------------
interface srec_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       line_end;

    modport source (output valid, output text_char, output line_end, input ready);
    modport sink   (input valid, input text_char, input line_end, output ready);
endinterface

FILE: hw/rtl/srec_result_if.sv
// ----------------------------------------------------------------------------
// srec_result_if
// Line verdict channel: one beat per completed line.
// ----------------------------------------------------------------------------
interface srec_result_if;
    logic        valid;
    logic        ready;
    logic        file_ok;
    logic        line_checksum_bad;
    logic        line_syntax_bad;
    logic [3:0]  record_type;
    logic [15:0] line_number;

    modport source (
        output valid, output file_ok, output line_checksum_bad,
        output line_syntax_bad, output record_type, output line_number,
        input ready
    );
    modport sink (
        input valid, input file_ok, input line_checksum_bad,
        input line_syntax_bad, input record_type, input line_number,
        output ready
    );
endinterface

FILE: hw/rtl/srec_line_parse.sv
// ----------------------------------------------------------------------------
// srec_line_parse
// Per-line parser: tracks the character position, pairs hex digits into bytes,
// accumulates the record sum and captures the checksum byte.
// ----------------------------------------------------------------------------
module srec_line_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             text_char,
    input  logic                   line_end,
    output srec_pkg::line_status_t status
);

    logic [9:0] pos_reg,   pos_next;
    logic [4:0] hi_reg,    hi_next;
    logic [7:0] count_reg, count_next;
    logic [7:0] sum_reg,   sum_next;
    logic [7:0] cks_reg,   cks_next;
    logic       start_reg, start_next;
    logic [7:0] type_reg,  type_next;
    logic       done_reg,  done_next;

    logic [4:0] nibble;
    logic [8:0] byte_wide;
    logic [7:0] byte_val;
    logic [9:0] pos_m2;
    logic [8:0] byte_idx;

    assign nibble    = srec_pkg::decode_nibble(text_char);
    // a bad high nibble (16) falls off the top, a bad low nibble sets bit 4
    assign byte_wide = {hi_reg, 4'b0000} | {4'b0000, nibble};
    assign byte_val  = byte_wide[7:0];
    assign pos_m2    = pos_reg - 10'd2;
    assign byte_idx  = pos_m2[9:1];

    always_comb
    begin
        pos_next   = pos_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        cks_next   = cks_reg;
        start_next = start_reg;
        type_next  = type_reg;
        done_next  = done_reg;

        if (pos_reg == 10'd0)
        begin
            start_next = (text_char == srec_pkg::CHAR_S);
        end
        else if (pos_reg == 10'd1)
        begin
            type_next = text_char;
        end
        else if (!done_reg)
        begin
            if (!pos_reg[0])
            begin
                hi_next = nibble;
            end
            else if (byte_idx == 9'd0)
            begin
                count_next = byte_val;
                if (byte_val == 8'd0)
                begin
                    cks_next  = byte_val;
                    done_next = 1'b1;
                end
                else
                begin
                    sum_next = byte_val;
                end
            end
            else if (byte_idx < {1'b0, count_reg})
            begin
                sum_next = sum_reg + byte_val;
            end
            else
            begin
                cks_next  = byte_val;
                done_next = 1'b1;
            end
        end

        if (pos_reg != srec_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hi_reg    <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            cks_reg   <= '0;
            start_reg <= 1'b0;
            type_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (line_end)
            begin
                pos_reg   <= '0;
                hi_reg    <= '0;
                count_reg <= '0;
                sum_reg   <= '0;
                cks_reg   <= '0;
                start_reg <= 1'b0;
                type_reg  <= '0;
                done_reg  <= 1'b0;
            end
            else
            begin
                pos_reg   <= pos_next;
                hi_reg    <= hi_next;
                count_reg <= count_next;
                sum_reg   <= sum_next;
                cks_reg   <= cks_next;
                start_reg <= start_next;
                type_reg  <= type_next;
                done_reg  <= done_next;
            end
        end
    end

    always_comb
    begin
        status.start_is_s     = start_next;
        status.type_char      = type_next;
        status.checksum_done  = done_next;
        status.checksum_match = ((~sum_next) == cks_next);
    end

endmodule

FILE: hw/rtl/srec_line_checker.sv
// ----------------------------------------------------------------------------
// srec_line_checker
// Streaming S-record checker: verifies each line's checksum and syntax and
// keeps a running verdict over the whole file.
// ----------------------------------------------------------------------------
// Characters are taken one per beat at a sustained rate of one per cycle; a
// registered input stage feeds a single pass of decode, byte add and counter
// update, and a line's verdict is loaded into the output register as its last
// character leaves the input stage. A result waiting on the output side
// only stalls the input when the next line end reaches the parse stage.
// Per-type, checksum error, syntax error and line counters are COUNTER_WIDTH
// bits wide and saturate; line_number saturates at 65535.
module srec_line_checker #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    srec_char_if.sink            chars,
    srec_result_if.source        verdict
);

    localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_end_reg;
    logic       s1_adv;
    logic       s1_fire_end;

    // output register
    logic        out_valid_reg;
    logic        out_ok_reg;
    logic        out_cks_reg;
    logic        out_syn_reg;
    logic [3:0]  out_type_reg;
    logic [15:0] out_line_reg;

    // file-level counters
    logic [COUNTER_WIDTH-1:0] type_cnt_reg  [srec_pkg::REC_TYPES];
    logic [COUNTER_WIDTH-1:0] type_cnt_next [srec_pkg::REC_TYPES];
    logic [COUNTER_WIDTH-1:0] cks_err_reg,  cks_err_next;
    logic [COUNTER_WIDTH-1:0] syn_err_reg,  syn_err_next;
    logic [COUNTER_WIDTH-1:0] lines_reg,    lines_next;

    srec_pkg::line_status_t status;

    logic [7:0]  digit_wide;
    logic [3:0]  digit;
    logic        syn_bad;
    logic        cks_bad;
    logic [3:0]  rec_type;
    logic        file_ok;
    logic [31:0] lines_ext;
    logic [15:0] line_number;
    logic [1:0]  data_seen;
    logic [1:0]  term_seen;

    assign s1_adv      = s1_valid_reg && (!s1_end_reg || !out_valid_reg || verdict.ready);
    assign s1_fire_end = s1_adv && s1_end_reg;
    assign chars.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            s1_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.ready && chars.valid)
        begin
            s1_char_reg <= chars.text_char;
            s1_end_reg  <= chars.line_end;
        end
    end

    srec_line_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (s1_adv),
        .text_char (s1_char_reg),
        .line_end  (s1_end_reg),
        .status    (status)
    );

    // line classification
    assign digit_wide = status.type_char - srec_pkg::CHAR_0;
    assign digit      = digit_wide[3:0];

    always_comb
    begin
        syn_bad  = !status.start_is_s
                 || !(status.type_char inside {[srec_pkg::CHAR_0:srec_pkg::CHAR_9]})
                 || (digit == srec_pkg::REC_S6);
        cks_bad  = !syn_bad && (digit != srec_pkg::REC_S4)
                 && (!status.checksum_done || !status.checksum_match);
        rec_type = syn_bad ? srec_pkg::REC_NONE : digit;
    end

    // saturating counter updates
    always_comb
    begin
        lines_next   = (lines_reg != CNT_MAX) ? lines_reg + 1'b1 : lines_reg;
        syn_err_next = (syn_bad && syn_err_reg != CNT_MAX) ? syn_err_reg + 1'b1
                                                           : syn_err_reg;
        cks_err_next = (cks_bad && cks_err_reg != CNT_MAX) ? cks_err_reg + 1'b1
                                                           : cks_err_reg;
        for (int i = 0; i < srec_pkg::REC_TYPES; i++)
        begin
            if (!syn_bad && digit == 4'(i) && type_cnt_reg[i] != CNT_MAX)
                type_cnt_next[i] = type_cnt_reg[i] + 1'b1;
            else
                type_cnt_next[i] = type_cnt_reg[i];
        end
    end

    // file verdict from the counters including this line
    always_comb
    begin
        data_seen = 2'(type_cnt_next[1] != '0) + 2'(type_cnt_next[2] != '0)
                  + 2'(type_cnt_next[3] != '0);
        term_seen = 2'(type_cnt_next[7] != '0) + 2'(type_cnt_next[8] != '0)
                  + 2'(type_cnt_next[9] != '0);
        file_ok   = (syn_err_next == '0) && (cks_err_next == '0)
                  && (type_cnt_next[srec_pkg::REC_S0] <= COUNTER_WIDTH'(1))
                  && (type_cnt_next[srec_pkg::REC_S4] == '0)
                  && (data_seen < 2'd2) && (term_seen < 2'd2);
    end

    assign lines_ext   = 32'(lines_next);
    assign line_number = (lines_ext > 32'd65535) ? 16'hFFFF : lines_ext[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lines_reg   <= '0;
            syn_err_reg <= '0;
            cks_err_reg <= '0;
            for (int i = 0; i < srec_pkg::REC_TYPES; i++)
            begin
                type_cnt_reg[i] <= '0;
            end
        end
        else if (s1_fire_end)
        begin
            lines_reg   <= lines_next;
            syn_err_reg <= syn_err_next;
            cks_err_reg <= cks_err_next;
            for (int i = 0; i < srec_pkg::REC_TYPES; i++)
            begin
                type_cnt_reg[i] <= type_cnt_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (verdict.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire_end)
        begin
            out_ok_reg   <= file_ok;
            out_cks_reg  <= cks_bad;
            out_syn_reg  <= syn_bad;
            out_type_reg <= rec_type;
            out_line_reg <= line_number;
        end
    end

    assign verdict.valid             = out_valid_reg;
    assign verdict.file_ok           = out_ok_reg;
    assign verdict.line_checksum_bad = out_cks_reg;
    assign verdict.line_syntax_bad   = out_syn_reg;
    assign verdict.record_type       = out_type_reg;
    assign verdict.line_number       = out_line_reg;

`ifndef SYNTHESIS
    // a new verdict only comes from a line end leaving the input stage
    a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_end_reg))
        else $error("verdict without a line end");

    // a stalled input stage keeps its character
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_char_reg)
                                       && $stable(s1_end_reg)))
        else $error("input stage lost a beat");

    // a syntax-bad line carries no type and no checksum verdict
    a_syntax_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_syn_reg) |-> (!out_cks_reg
                                            && out_type_reg == srec_pkg::REC_NONE))
        else $error("syntax-bad line with type or checksum flag");

    // any line error fails the file
    a_error_fails_file: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_cks_reg || out_syn_reg)) |-> !out_ok_reg)
        else $error("line error with file_ok set");
`endif

endmodule

FILE: verif/tb_srec_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_srec_line_checker
// Streams S-record text into the line checker one character per beat. A short
// table of handwritten lines comes first, then random records, many of them
// corrupted, and noise lines. Every verdict is checked field by field against
// the row's typed verdict or an in-bench model of the parser and file rules.
// ----------------------------------------------------------------------------
module tb_srec_line_checker;

    localparam int CW          = 16;
    localparam int CHAR_BUDGET = 1700;
    localparam longint unsigned CNT_TOP = (64'd1 << CW) - 1;

    // record type codes not named in the package
    localparam logic [3:0] REC_S1 = 4'd1;
    localparam logic [3:0] REC_S2 = 4'd2;
    localparam logic [3:0] REC_S3 = 4'd3;
    localparam logic [3:0] REC_S5 = 4'd5;
    localparam logic [3:0] REC_S7 = 4'd7;
    localparam logic [3:0] REC_S8 = 4'd8;
    localparam logic [3:0] REC_S9 = 4'd9;

    typedef struct packed {
        logic        file_ok;
        logic        cks_bad;
        logic        syn_bad;
        logic [3:0]  rtype;
        logic [15:0] line_no;
    } line_verdict_t;

    typedef struct {
        string         text;
        bit            typed;
        line_verdict_t want;
    } text_row_t;

    logic clk;
    logic rst_n;

    srec_char_if   chars_bus();
    srec_result_if verdict_bus();

    srec_line_checker #(
        .COUNTER_WIDTH(CW)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_bus),
        .verdict (verdict_bus)
    );

    // parser model state
    int unsigned     pos;
    logic [4:0]      hi_nib;
    logic [7:0]      cnt_byte;
    logic [7:0]      sum_acc;
    logic [7:0]      cks_byte;
    logic [7:0]      type_ch;
    logic            saw_s;
    logic            cks_done;
    longint unsigned rec_cnt [srec_pkg::REC_TYPES];
    longint unsigned cks_errs;
    longint unsigned syn_errs;
    longint unsigned line_cnt;

    line_verdict_t verdicts_due[$];
    logic [7:0]    line_buf[$];
    text_row_t     text_rows[$];

    int fail_cnt;
    int chars_sent;
    int lines_sent;
    int lines_checked;
    int cks_bad_seen;
    int syn_bad_seen;
    int longest_line;
    bit src_steady;
    bit sink_steady;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("srec_line_checker test failed");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= srec_pkg::CHAR_0 && c <= srec_pkg::CHAR_9)
            return 5'(c - srec_pkg::CHAR_0);
        if (c >= srec_pkg::CHAR_A && c <= srec_pkg::CHAR_F)
            return 5'(c - srec_pkg::HEX_A_OFFSET);
        return srec_pkg::NIBBLE_BAD;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? srec_pkg::CHAR_0 + {4'b0, n}
                           : srec_pkg::CHAR_A + {4'b0, n} - 8'd10;
    endfunction

    function automatic longint unsigned bumped(input longint unsigned v);
        return (v < CNT_TOP) ? v + 1 : v;
    endfunction

    function automatic line_verdict_t verdict_of(input logic ok, input logic cks,
                                                 input logic syn, input logic [3:0] rt,
                                                 input logic [15:0] n);
        line_verdict_t v;
        v.file_ok = ok;
        v.cks_bad = cks;
        v.syn_bad = syn;
        v.rtype   = rt;
        v.line_no = n;
        return v;
    endfunction

    function automatic logic file_ok_now();
        int data_kinds;
        int end_kinds;
        data_kinds = (rec_cnt[REC_S1] != 0) + (rec_cnt[REC_S2] != 0) + (rec_cnt[REC_S3] != 0);
        end_kinds  = (rec_cnt[REC_S7] != 0) + (rec_cnt[REC_S8] != 0) + (rec_cnt[REC_S9] != 0);
        if (syn_errs != 0 || cks_errs != 0)
            return 1'b0;
        if (rec_cnt[srec_pkg::REC_S0] > 1 || rec_cnt[srec_pkg::REC_S4] != 0)
            return 1'b0;
        return (data_kinds < 2) && (end_kinds < 2);
    endfunction

    function automatic logic [3:0] pick_code();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return srec_pkg::REC_S0;
        if (r < 50)
        begin
            case ($urandom_range(0, 2))
                0:       return REC_S1;
                1:       return REC_S2;
                default: return REC_S3;
            endcase
        end
        if (r < 60)
            return REC_S5;
        if (r < 80)
        begin
            case ($urandom_range(0, 2))
                0:       return REC_S7;
                1:       return REC_S8;
                default: return REC_S9;
            endcase
        end
        if (r < 88)
            return srec_pkg::REC_S4;
        if (r < 94)
            return srec_pkg::REC_S6;
        return 4'($urandom_range(0, 9));
    endfunction

    task automatic clear_line_state();
        pos      = 0;
        hi_nib   = '0;
        cnt_byte = '0;
        sum_acc  = '0;
        cks_byte = '0;
        type_ch  = '0;
        saw_s    = 1'b0;
        cks_done = 1'b0;
    endtask

    // advance the parser model by one character; r is valid when last is set
    task automatic track_char(input logic [7:0] c, input logic last, output line_verdict_t r);
        logic [4:0] d;
        logic [8:0] joined;
        int unsigned k;
        r = '0;
        if (pos == 0)
            saw_s = (c == srec_pkg::CHAR_S);
        else if (pos == 1)
            type_ch = c;
        else if (!cks_done)
        begin
            d = nibble_of(c);
            if (pos[0] == 1'b0)
                hi_nib = d;
            else
            begin
                // a bad low nibble (16) sets bit 4 of the byte; a bad high nibble falls outside joined[7:0]
                joined = {hi_nib, 4'b0} | {4'b0, d};
                k = (pos - 2) >> 1;
                if (k == 0)
                begin
                    cnt_byte = joined[7:0];
                    if (joined[7:0] == 8'd0)
                    begin
                        cks_byte = 8'd0;
                        cks_done = 1'b1;
                    end
                    else
                        sum_acc = joined[7:0];
                end
                else if (k < cnt_byte)
                    sum_acc = sum_acc + joined[7:0];
                else
                begin
                    cks_byte = joined[7:0];
                    cks_done = 1'b1;
                end
            end
        end
        if (pos < srec_pkg::POS_MAX)
            pos++;

        if (last)
        begin
            line_cnt = bumped(line_cnt);
            r.rtype  = srec_pkg::REC_NONE;
            if (!saw_s || type_ch < srec_pkg::CHAR_0 || type_ch > srec_pkg::CHAR_9
                || type_ch - srec_pkg::CHAR_0 == srec_pkg::REC_S6)
            begin
                r.syn_bad = 1'b1;
                syn_errs  = bumped(syn_errs);
            end
            else
            begin
                r.rtype = 4'(type_ch - srec_pkg::CHAR_0);
                if (r.rtype != srec_pkg::REC_S4 && (!cks_done || ~sum_acc != cks_byte))
                begin
                    r.cks_bad = 1'b1;
                    cks_errs  = bumped(cks_errs);
                end
                rec_cnt[r.rtype] = bumped(rec_cnt[r.rtype]);
            end
            r.file_ok = file_ok_now();
            r.line_no = (line_cnt > 65535) ? 16'hFFFF : line_cnt[15:0];
            clear_line_state();
        end
    endtask

    task automatic add_row(input string s, input bit typed, input line_verdict_t want);
        text_row_t row;
        row.text  = s;
        row.typed = typed;
        row.want  = want;
        text_rows.push_back(row);
    endtask

    task automatic put_byte(input logic [7:0] b);
        line_buf.push_back(hex_digit(b[7:4]));
        line_buf.push_back(hex_digit(b[3:0]));
    endtask

    task automatic make_record(input logic [3:0] code, input int cnt);
        logic [7:0] sum;
        logic [7:0] b;
        line_buf.delete();
        line_buf.push_back(srec_pkg::CHAR_S);
        line_buf.push_back(srec_pkg::CHAR_0 + {4'b0, code});
        put_byte(8'(cnt));
        if (cnt == 0)
        begin
            put_byte($urandom_range(0, 1) ? 8'hFF : 8'($urandom));
            return;
        end
        sum = 8'(cnt);
        repeat (cnt - 1)
        begin
            b = 8'($urandom);
            put_byte(b);
            sum = sum + b;
        end
        put_byte(~sum);
    endtask

    task automatic make_random_line();
        int r;
        int n;
        int last;
        logic [4:0] d;
        r = $urandom_range(0, 99);
        if (r >= 87)
        begin
            line_buf.delete();
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(8'($urandom));
            return;
        end
        make_record(pick_code(), ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8));
        if (r >= 75)
        begin
            // damaged header
            line_buf[$urandom_range(0, 1)] = 8'($urandom);
            return;
        end
        last = line_buf.size() - 1;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            d = nibble_of(line_buf[last]);
            line_buf[last] = hex_digit(d[3:0] ^ 4'($urandom_range(1, 15)));
        end
        else if (r < 20)
        begin
            n = $urandom_range(1, last);
            repeat (n) void'(line_buf.pop_back());
        end
        else if (r < 30)
        begin
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(8'($urandom));
        end
        else if (r < 35)
            line_buf[$urandom_range(2, last)] = 8'($urandom);
        else if (r < 40)
        begin
            foreach (line_buf[i])
                if (i >= 2 && line_buf[i] >= srec_pkg::CHAR_A
                    && line_buf[i] <= srec_pkg::CHAR_F)
                    line_buf[i] = line_buf[i] + 8'd32;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic last, input bit typed,
                             input line_verdict_t want);
        line_verdict_t r;
        int gap;
        gap = src_steady ? 0 : idle_len();
        if (gap > 0)
        begin
            chars_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        chars_bus.valid     = 1'b1;
        chars_bus.text_char = c;
        chars_bus.line_end  = last;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        track_char(c, last, r);
        chars_sent++;
        if (last)
            verdicts_due.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic send_line(input bit typed, input line_verdict_t want);
        lines_sent++;
        if (line_buf.size() > longest_line)
            longest_line = line_buf.size();
        foreach (line_buf[i])
            push_char(line_buf[i], i == line_buf.size() - 1, typed, want);
    endtask

    task automatic wait_for_results();
        chars_bus.valid = 1'b0;
        while (verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic report_field(input string name, input logic [15:0] exp_v,
                                input logic [15:0] got_v);
        if (exp_v !== got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // result sink: ready drops at random, with calm stretches
    initial
    begin
        int stall_left;
        stall_left        = 0;
        verdict_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 149) == 0)
                sink_steady = !sink_steady;
            if (stall_left > 0)
            begin
                verdict_bus.ready = 1'b0;
                stall_left--;
            end
            else
            begin
                verdict_bus.ready = 1'b1;
                if (!sink_steady && $urandom_range(0, 3) == 0)
                    stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin : check_verdicts
        line_verdict_t exp_v;
        if (rst_n && verdict_bus.valid && verdict_bus.ready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("%0t: verdict beat with nothing expected, line_number %0d",
                         $time, verdict_bus.line_number);
                fail_cnt++;
            end
            else
            begin
                exp_v = verdicts_due.pop_front();
                report_field("file_ok", 16'(exp_v.file_ok), 16'(verdict_bus.file_ok));
                report_field("line_checksum_bad", 16'(exp_v.cks_bad),
                             16'(verdict_bus.line_checksum_bad));
                report_field("line_syntax_bad", 16'(exp_v.syn_bad),
                             16'(verdict_bus.line_syntax_bad));
                report_field("record_type", 16'(exp_v.rtype), 16'(verdict_bus.record_type));
                report_field("line_number", exp_v.line_no, verdict_bus.line_number);
                lines_checked++;
                if (verdict_bus.line_checksum_bad)
                    cks_bad_seen++;
                if (verdict_bus.line_syntax_bad)
                    syn_bad_seen++;
            end
        end
    end

    initial
    begin
        int rand_start;
        int long_at;
        int line_idx;
        int target;
        logic [7:0] c;

        rst_n               = 1'b0;
        chars_bus.valid     = 1'b0;
        chars_bus.text_char = 8'd0;
        chars_bus.line_end  = 1'b0;
        clear_line_state();
        foreach (rec_cnt[i])
            rec_cnt[i] = 0;
        cks_errs = 0;
        syn_errs = 0;
        line_cnt = 0;

        // typed rows are read straight off the rules; the rest go through the model
        add_row("S0030000FC", 1'b1,
                verdict_of(1'b1, 1'b0, 1'b0, srec_pkg::REC_S0, 16'd1));
        add_row("S1050000AB123D", 1'b0, '0);
        add_row("S104FFFFFFFE", 1'b0, '0);
        add_row("S5030001FB", 1'b0, '0);
        add_row("S9030000FC", 1'b0, '0);
        add_row("S8030000FC", 1'b1, verdict_of(1'b0, 1'b0, 1'b0, REC_S8, 16'd6));
        add_row("S0030000FD", 1'b1,
                verdict_of(1'b0, 1'b1, 1'b0, srec_pkg::REC_S0, 16'd7));
        add_row("S00", 1'b1, verdict_of(1'b0, 1'b1, 1'b0, srec_pkg::REC_S0, 16'd8));
        add_row("S600", 1'b1, verdict_of(1'b0, 1'b0, 1'b1, srec_pkg::REC_NONE, 16'd9));
        add_row("X1030000FC", 1'b1,
                verdict_of(1'b0, 1'b0, 1'b1, srec_pkg::REC_NONE, 16'd10));
        add_row("S", 1'b1, verdict_of(1'b0, 1'b0, 1'b1, srec_pkg::REC_NONE, 16'd11));
        add_row("S/", 1'b0, '0);
        add_row("S:", 1'b0, '0);
        add_row("S400", 1'b1, verdict_of(1'b0, 1'b0, 1'b0, srec_pkg::REC_S4, 16'd14));
        add_row("S300FF", 1'b1, verdict_of(1'b0, 1'b1, 1'b0, REC_S3, 16'd15));
        add_row("S7030000FC", 1'b0, '0);
        add_row("S103@:G/`f", 1'b0, '0);
        add_row("S1030000FCZZ", 1'b0, '0);
        add_row("S2050000AB123DS9", 1'b0, '0);
        add_row("s1030000FC", 1'b0, '0);
        add_row("S1030000fc", 1'b0, '0);
        add_row("S\377", 1'b0, '0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (text_rows[i])
        begin
            line_buf.delete();
            for (int j = 0; j < text_rows[i].text.len(); j++)
                line_buf.push_back(text_rows[i].text[j]);
            send_line(text_rows[i].typed, text_rows[i].want);
        end
        wait_for_results();

        rand_start = chars_sent;
        long_at    = $urandom_range(3, 30);
        line_idx   = 0;
        while (chars_sent - rand_start < CHAR_BUDGET)
        begin
            if ($urandom_range(0, 19) == 0)
                src_steady = !src_steady;
            if (line_idx == long_at)
            begin
                // full 255-byte record, then filler past the position cap
                make_record(pick_code(), 255);
                target = $urandom_range(1030, 1060);
                while (line_buf.size() < target)
                begin
                    c = 8'($urandom);
                    if (c != srec_pkg::CHAR_S)
                        line_buf.push_back(c);
                end
            end
            else
                make_random_line();
            send_line(1'b0, '0);
            if ($urandom_range(0, 24) == 0)
                wait_for_results();
            line_idx++;
        end

        wait_for_results();
        repeat (8) @(posedge clk);

        $display("covered %0d characters in %0d lines, longest line %0d characters",
                 chars_sent, lines_sent, longest_line);
        $display("%0d verdicts checked, %0d flagged checksum errors, %0d syntax errors",
                 lines_checked, cks_bad_seen, syn_bad_seen);
        if (fail_cnt == 0)
            $display("srec_line_checker test passed");
        else
            $display("srec_line_checker test failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/srec_pkg.sv
hw/rtl/srec_char_if.sv
hw/rtl/srec_result_if.sv
hw/rtl/srec_line_parse.sv
hw/rtl/srec_line_checker.sv
verif/tb_srec_line_checker.sv
